// ===== hdl/svmc_pkg.sv =====
// ----------------------------------------------------------------------------
// svmc_pkg: shared codes and types for the state vector measure block
// Operation and status codes, word widths, the probability constant and the divider status bundle.
// ----------------------------------------------------------------------------
package svmc_pkg;

    // operation codes
    localparam logic [2:0] OP_INIT    = 3'd0;
    localparam logic [2:0] OP_EXPAND  = 3'd1;
    localparam logic [2:0] OP_WRITE   = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_MEASURE = 3'd4;

    // status codes
    localparam logic [2:0] STAT_OK        = 3'd0;
    localparam logic [2:0] STAT_TOO_MANY  = 3'd1;
    localparam logic [2:0] STAT_RANGE     = 3'd2;
    localparam logic [2:0] STAT_ZERO_NORM = 3'd3;
    localparam logic [2:0] STAT_NOT_INIT  = 3'd4;

    // stream word widths
    localparam int IN_W  = 72;
    localparam int OUT_W = 40;

    // probability 1.0 in unsigned Q1.30
    localparam logic [30:0] PROB_ONE = 31'h4000_0000;

    typedef struct packed {
        logic done;
        logic ovf;
    } div_stat_t;

endpackage

// ===== hdl/svmc_div.sv =====
// ----------------------------------------------------------------------------
// svmc_div: renormalization divider
// Computes round(mag * 2^30 / s) one quotient bit per cycle, flags overflow.
// ----------------------------------------------------------------------------
module svmc_div #(
    parameter int AMP_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [AMP_BITS-1:0]   mag,
    input  logic [30:0]           s,
    output svmc_pkg::div_stat_t   stat,
    output logic [AMP_BITS-1:0]   quot
);

    localparam int NW = AMP_BITS + 31;
    localparam int KW = $clog2(AMP_BITS);

    logic [NW-1:0]       numer;
    logic                ovf_now;
    logic [NW-1:0]       rem_reg;
    logic [NW-1:0]       dvs_reg;
    logic [KW-1:0]       k_reg;
    logic [AMP_BITS-1:0] quot_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                ovf_reg;

    // numerator with half the divisor added for round to nearest
    assign numer   = (NW'(mag) << 30) + NW'(s >> 1);
    assign ovf_now = numer >= (NW'(s) << AMP_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= !ovf_now;
                done_reg <= ovf_now;
                ovf_reg  <= ovf_now;
            end
            else if (busy_reg)
            begin
                if (k_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= numer;
            dvs_reg  <= NW'(s) << (AMP_BITS - 1);
            k_reg    <= KW'(AMP_BITS - 1);
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            // restore step: subtract when it fits, shift in the quotient bit
            if (rem_reg >= dvs_reg)
            begin
                rem_reg  <= rem_reg - dvs_reg;
                quot_reg <= {quot_reg[AMP_BITS-2:0], 1'b1};
            end
            else
            begin
                quot_reg <= {quot_reg[AMP_BITS-2:0], 1'b0};
            end
            dvs_reg <= dvs_reg >> 1;
            k_reg   <= k_reg - KW'(1);
        end
    end

    assign stat.done = done_reg;
    assign stat.ovf  = ovf_reg;
    assign quot      = quot_reg;

endmodule

// ===== hdl/state_vector_measure_collapse.sv =====
// ----------------------------------------------------------------------------
// state_vector_measure_collapse: fixed-point state vector with measurement
// Holds 2^n complex amplitudes and runs init, expand, write, read and
// single-qubit projective measurement with renormalization.
// ----------------------------------------------------------------------------
// Measure sums the squared magnitudes of the entries with the selected qubit at zero,
// skips the rest, takes the square root of the chosen probability, then renormalizes
// each kept entry in the shared divider and clears each entry of the other half.
// One word is worked at a time; the next word is taken while a result waits.
// Reset clears control state, qubit count and init flag; amplitudes stay undefined.
module state_vector_measure_collapse #(
    parameter int MAX_QUBITS = 10,
    parameter int AMP_BITS   = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // operation[2:0], qubit_count[6:3], entry_index[16:7], qubit_select[20:17],
    // write_real[36:21], write_imag[52:37], random_draw[68:53], zero pad
    input  logic [svmc_pkg::IN_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // outcome[0], read_real[16:1], read_imag[32:17], status[35:33], zero pad
    output logic [svmc_pkg::OUT_W-1:0] m_tdata
);

    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int AW    = MAX_QUBITS;
    localparam int DW    = MAX_QUBITS + 1;          // counter holds DEPTH
    localparam int CW    = (DW > 10) ? DW : 10;     // index compare width
    localparam int QW    = $clog2(MAX_QUBITS + 1);
    localparam int SW    = ((QW > 4) ? QW : 4) + 1; // qubit count sum width
    localparam int WW    = 2 * AMP_BITS;
    localparam int SQW   = 2 * AMP_BITS + 1;
    localparam int PW    = SQW + 16;
    localparam int SQ_FRAC = 2 * (AMP_BITS - 1);
    localparam int SH_R  = (SQ_FRAC >= 30) ? SQ_FRAC - 30 : 0;
    localparam int SH_L  = (SQ_FRAC < 30) ? 30 - SQ_FRAC : 0;

    localparam logic [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
    localparam logic [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_INIT   = 5'd1;
    localparam logic [4:0] S_EXP_RD = 5'd2;
    localparam logic [4:0] S_EXP_WR = 5'd3;
    localparam logic [4:0] S_RD_CAP = 5'd4;
    localparam logic [4:0] S_M_RD   = 5'd5;
    localparam logic [4:0] S_M_SQR  = 5'd6;
    localparam logic [4:0] S_M_SQI  = 5'd7;
    localparam logic [4:0] S_M_ACC  = 5'd8;
    localparam logic [4:0] S_M_DEC  = 5'd9;
    localparam logic [4:0] S_M_SQRT = 5'd10;
    localparam logic [4:0] S_M_NRD  = 5'd11;
    localparam logic [4:0] S_M_DRS  = 5'd12;
    localparam logic [4:0] S_M_DRW  = 5'd13;
    localparam logic [4:0] S_M_DIS  = 5'd14;
    localparam logic [4:0] S_M_DIW  = 5'd15;
    localparam logic [4:0] S_RESP   = 5'd16;

    // input word fields
    logic [2:0]         in_op;
    logic [3:0]         in_count;
    logic [9:0]         in_index;
    logic [3:0]         in_qsel;
    logic signed [15:0] in_wre;
    logic signed [15:0] in_wim;
    logic [15:0]        in_rnd;

    assign in_op    = s_tdata[2:0];
    assign in_count = s_tdata[6:3];
    assign in_index = s_tdata[16:7];
    assign in_qsel  = s_tdata[20:17];
    assign in_wre   = s_tdata[36:21];
    assign in_wim   = s_tdata[52:37];
    assign in_rnd   = s_tdata[68:53];

    // sequencer and working registers
    logic [4:0]           state_reg, state_next;
    logic [QW-1:0]        active_reg, active_next;
    logic                 init_reg, init_next;
    logic [DW-1:0]        cnt_reg, cnt_next;
    logic [DW-1:0]        lim_reg, lim_next;
    logic [3:0]           sh_reg, sh_next;
    logic [3:0]           qsel_reg, qsel_next;
    logic [15:0]          rnd_reg, rnd_next;
    logic [SQW-1:0]       sq_reg, sq_next;
    logic [30:0]          p0_reg, p0_next;
    logic [60:0]          x_reg, x_next;
    logic [61:0]          r_reg, r_next;
    logic [60:0]          bv_reg, bv_next;
    logic [30:0]          s_reg, s_next;
    logic [AMP_BITS-1:0]  nre_reg, nre_next;
    logic                 bit_reg, bit_next;
    logic                 res_out_reg, res_out_next;
    logic [15:0]          res_re_reg, res_re_next;
    logic [15:0]          res_im_reg, res_im_next;
    logic [2:0]           res_st_reg, res_st_next;
    logic                 out_valid_reg, out_valid_next;
    logic [svmc_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    // amplitude memory, word is {imag, real}
    logic [WW-1:0]        amp_mem [DEPTH];
    logic [WW-1:0]        rdata_reg;
    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [WW-1:0]        mem_wdata;

    // shared datapath signals
    logic                 accept;
    logic [DW-1:0]        dim;
    logic [CW-1:0]        idx_ext;
    logic [SW-1:0]        sum_q;
    logic [DW-1:0]        cnt_shift_q;
    logic [DW-1:0]        low_mask;
    logic [DW-1:0]        exp_src;
    logic [AMP_BITS-1:0]  rd_re, rd_im;
    logic [AMP_BITS-1:0]  mag_re, mag_im;
    logic [AMP_BITS-1:0]  mul_a;
    logic [WW-1:0]        mul_p;
    logic [PW-1:0]        sq_q;
    logic [PW:0]          psum;
    logic                 dec_bit;
    logic [30:0]          p_sel;
    logic [61:0]          trial;
    logic                 div_start;
    logic [AMP_BITS-1:0]  div_mag;
    svmc_pkg::div_stat_t  div_stat;
    logic [AMP_BITS-1:0]  div_quot;

    function automatic logic [AMP_BITS-1:0] amp_mag(input logic [AMP_BITS-1:0] v);
        return v[AMP_BITS-1] ? (~v + AMP_BITS'(1)) : v;
    endfunction

    // saturate a 16-bit signed write value to the amplitude format
    function automatic logic [AMP_BITS-1:0] to_amp(input logic [15:0] v);
        logic signed [63:0] w;
        logic signed [63:0] hi;
        w  = {{48{v[15]}}, v};
        hi = (64'sd1 <<< (AMP_BITS - 1)) - 64'sd1;
        if (w > hi)
            w = hi;
        else if (w < -hi - 64'sd1)
            w = -hi - 64'sd1;
        return w[AMP_BITS-1:0];
    endfunction

    // saturate an amplitude to the 16-bit read field
    function automatic logic [15:0] to_out16(input logic [AMP_BITS-1:0] a);
        logic signed [63:0] w;
        w = {{(64-AMP_BITS){a[AMP_BITS-1]}}, a};
        if (w > 64'sd32767)
            w = 64'sd32767;
        else if (w < -64'sd32768)
            w = -64'sd32768;
        return w[15:0];
    endfunction

    // apply sign and saturate a renormalized magnitude
    function automatic logic [AMP_BITS-1:0] renorm(input logic neg,
                                                   input logic [AMP_BITS-1:0] q,
                                                   input logic ovf);
        logic [AMP_BITS-1:0] r;
        if (!neg)
            r = (ovf || q > AMP_MAX) ? AMP_MAX : q;
        else
            r = (ovf || q > AMP_MIN) ? AMP_MIN : (~q + AMP_BITS'(1));
        return r;
    endfunction

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign dim         = DW'(1) << active_reg;
    assign idx_ext     = CW'(in_index);
    assign sum_q       = SW'(active_reg) + SW'(in_count);
    assign cnt_shift_q = cnt_reg >> qsel_reg;
    assign low_mask    = (DW'(1) << sh_reg) - DW'(1);
    assign exp_src     = cnt_reg >> sh_reg;

    assign rd_re  = rdata_reg[AMP_BITS-1:0];
    assign rd_im  = rdata_reg[WW-1:AMP_BITS];
    assign mag_re = amp_mag(rd_re);
    assign mag_im = amp_mag(rd_im);

    // the one multiplier: squares real then imaginary magnitude
    assign mul_a = (state_reg == S_M_SQR) ? mag_re : mag_im;
    assign mul_p = mul_a * mul_a;

    // square magnitude in Q2.30, then saturating accumulate
    assign sq_q = (PW'(sq_reg) >> SH_R) << SH_L;
    assign psum = (PW+1)'(p0_reg) + (PW+1)'(sq_q);

    assign dec_bit = !({1'b0, rnd_reg, 14'd0} < p0_reg);
    assign p_sel   = dec_bit ? (svmc_pkg::PROB_ONE - p0_reg) : p0_reg;
    assign trial   = r_reg + 62'(bv_reg);

    assign div_start = (state_reg == S_M_DRS) || (state_reg == S_M_DIS);
    assign div_mag   = (state_reg == S_M_DRS) ? mag_re : mag_im;

    svmc_div #(
        .AMP_BITS (AMP_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .mag   (div_mag),
        .s     (s_reg),
        .stat  (div_stat),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next     = state_reg;
        active_next    = active_reg;
        init_next      = init_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        sh_next        = sh_reg;
        qsel_next      = qsel_reg;
        rnd_next       = rnd_reg;
        sq_next        = sq_reg;
        p0_next        = p0_reg;
        x_next         = x_reg;
        r_next         = r_reg;
        bv_next        = bv_reg;
        s_next         = s_reg;
        nre_next       = nre_reg;
        bit_next       = bit_reg;
        res_out_next   = res_out_reg;
        res_re_next    = res_re_reg;
        res_im_next    = res_im_reg;
        res_st_next    = res_st_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[AW-1:0];
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = cnt_reg[AW-1:0];

        // drop the output word once taken
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_out_next = 1'b0;
                    res_re_next  = '0;
                    res_im_next  = '0;
                    res_st_next  = svmc_pkg::STAT_OK;
                    qsel_next    = in_qsel;
                    rnd_next     = in_rnd;
                    sh_next      = in_count;
                    state_next   = S_RESP;
                    if (in_op == svmc_pkg::OP_INIT)
                    begin
                        if (SW'(in_count) > SW'(MAX_QUBITS))
                            res_st_next = svmc_pkg::STAT_TOO_MANY;
                        else
                        begin
                            cnt_next    = '0;
                            lim_next    = DW'(1) << in_count;
                            active_next = QW'(in_count);
                            init_next   = 1'b1;
                            state_next  = S_INIT;
                        end
                    end
                    else if (in_op == svmc_pkg::OP_EXPAND || in_op == svmc_pkg::OP_WRITE ||
                             in_op == svmc_pkg::OP_READ || in_op == svmc_pkg::OP_MEASURE)
                    begin
                        if (!init_reg)
                            res_st_next = svmc_pkg::STAT_NOT_INIT;
                        else if (in_op == svmc_pkg::OP_EXPAND)
                        begin
                            if (sum_q > SW'(MAX_QUBITS))
                                res_st_next = svmc_pkg::STAT_TOO_MANY;
                            else if (in_count != 4'd0)
                            begin
                                // walk downward so sources are read before overwritten
                                cnt_next   = (DW'(1) << sum_q) - DW'(1);
                                state_next = S_EXP_RD;
                            end
                        end
                        else if (in_op == svmc_pkg::OP_WRITE || in_op == svmc_pkg::OP_READ)
                        begin
                            if (idx_ext >= CW'(dim))
                                res_st_next = svmc_pkg::STAT_RANGE;
                            else if (in_op == svmc_pkg::OP_WRITE)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = idx_ext[AW-1:0];
                                mem_wdata = {to_amp(in_wim), to_amp(in_wre)};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = idx_ext[AW-1:0];
                                state_next = S_RD_CAP;
                            end
                        end
                        else
                        begin
                            if (SW'(in_qsel) >= SW'(active_reg))
                                res_st_next = svmc_pkg::STAT_RANGE;
                            else
                            begin
                                cnt_next   = '0;
                                p0_next    = '0;
                                state_next = S_M_RD;
                            end
                        end
                    end
                end
            end

            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = (cnt_reg == '0) ? {{AMP_BITS{1'b0}}, AMP_MAX} : '0;
                cnt_next  = cnt_reg + DW'(1);
                if (cnt_reg == lim_reg - DW'(1))
                    state_next = S_RESP;
            end

            S_EXP_RD:
            begin
                if ((cnt_reg & low_mask) == '0)
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = exp_src[AW-1:0];
                    state_next = S_EXP_WR;
                end
                else
                begin
                    // entries with new low bits set start at zero
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg - DW'(1);
                end
            end

            S_EXP_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = rdata_reg;
                if (cnt_reg == '0)
                begin
                    active_next = QW'(SW'(active_reg) + SW'(sh_reg));
                    state_next  = S_RESP;
                end
                else
                begin
                    cnt_next   = cnt_reg - DW'(1);
                    state_next = S_EXP_RD;
                end
            end

            S_RD_CAP:
            begin
                res_re_next = to_out16(rd_re);
                res_im_next = to_out16(rd_im);
                state_next  = S_RESP;
            end

            S_M_RD:
            begin
                if (cnt_reg == dim)
                    state_next = S_M_DEC;
                else if (!cnt_shift_q[0])
                begin
                    mem_re     = 1'b1;
                    state_next = S_M_SQR;
                end
                else
                    cnt_next = cnt_reg + DW'(1);
            end

            S_M_SQR:
            begin
                sq_next    = SQW'(mul_p);
                state_next = S_M_SQI;
            end

            S_M_SQI:
            begin
                sq_next    = sq_reg + SQW'(mul_p);
                state_next = S_M_ACC;
            end

            S_M_ACC:
            begin
                p0_next    = (psum > (PW+1)'(svmc_pkg::PROB_ONE)) ?
                             svmc_pkg::PROB_ONE : psum[30:0];
                cnt_next   = cnt_reg + DW'(1);
                state_next = S_M_RD;
            end

            S_M_DEC:
            begin
                bit_next = dec_bit;
                if (p_sel == '0)
                begin
                    res_st_next = svmc_pkg::STAT_ZERO_NORM;
                    state_next  = S_RESP;
                end
                else
                begin
                    x_next     = {p_sel, 30'd0};
                    r_next     = '0;
                    bv_next    = 61'd1 << 60;
                    state_next = S_M_SQRT;
                end
            end

            S_M_SQRT:
            begin
                // one digit of the integer square root per cycle
                if (62'(x_reg) >= trial)
                begin
                    x_next = x_reg - 61'(trial);
                    r_next = (r_reg >> 1) + 62'(bv_reg);
                end
                else
                    r_next = r_reg >> 1;
                bv_next = bv_reg >> 2;
                if (bv_reg == 61'd1)
                begin
                    s_next     = r_next[30:0];
                    cnt_next   = '0;
                    state_next = S_M_NRD;
                end
            end

            S_M_NRD:
            begin
                if (cnt_reg == dim)
                begin
                    res_out_next = bit_reg;
                    state_next   = S_RESP;
                end
                else if (cnt_shift_q[0] != bit_reg)
                begin
                    // clear the half that was not observed
                    mem_we   = 1'b1;
                    cnt_next = cnt_reg + DW'(1);
                end
                else
                begin
                    mem_re     = 1'b1;
                    state_next = S_M_DRS;
                end
            end

            S_M_DRS:
            begin
                state_next = S_M_DRW;
            end

            S_M_DRW:
            begin
                if (div_stat.done)
                begin
                    nre_next   = renorm(rd_re[AMP_BITS-1], div_quot, div_stat.ovf);
                    state_next = S_M_DIS;
                end
            end

            S_M_DIS:
            begin
                state_next = S_M_DIW;
            end

            S_M_DIW:
            begin
                if (div_stat.done)
                begin
                    mem_we     = 1'b1;
                    mem_wdata  = {renorm(rd_im[AMP_BITS-1], div_quot, div_stat.ovf),
                                  nre_reg};
                    cnt_next   = cnt_reg + DW'(1);
                    state_next = S_M_NRD;
                end
            end

            S_RESP:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {4'd0, res_st_reg, res_im_reg, res_re_reg, res_out_reg};
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            amp_mem[mem_waddr] <= mem_wdata;
        if (mem_re)
            rdata_reg <= amp_mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            active_reg    <= '0;
            init_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            p0_reg        <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            active_reg    <= active_next;
            init_reg      <= init_next;
            out_valid_reg <= out_valid_next;
            p0_reg        <= p0_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        lim_reg      <= lim_next;
        sh_reg       <= sh_next;
        qsel_reg     <= qsel_next;
        rnd_reg      <= rnd_next;
        sq_reg       <= sq_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        bv_reg       <= bv_next;
        s_reg        <= s_next;
        nre_reg      <= nre_next;
        bit_reg      <= bit_next;
        res_out_reg  <= res_out_next;
        res_re_reg   <= res_re_next;
        res_im_reg   <= res_im_next;
        res_st_reg   <= res_st_next;
        out_data_reg <= out_data_next;
    end

    // qubit count never passes the configured maximum
    a_active_max: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg <= QW'(MAX_QUBITS))
        else $error("active qubit count above maximum");

    // accumulated probability is saturated so it never exceeds one
    a_p0_max: assert property (@(posedge clk) disable iff (!rst_n)
        p0_reg <= svmc_pkg::PROB_ONE)
        else $error("probability sum above one");

    // an accepted word starts work, so the input closes next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input still open after accept");

    // a result leaving the sequencer lands in the output register
    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && (!out_valid_reg || m_tready)) |=> (m_tvalid && s_tready))
        else $error("result not presented");

endmodule
